FILE: rtl/tws_pkg.sv
// Timing wheel scheduler: shared types, sizes and slot arithmetic.
// Used by every module of the block; depends on nothing.
package tws_pkg;

    localparam int SLOTS       = 256;
    localparam int TIMERS      = 16;
    localparam int MAX_RESULTS = 16;
    localparam int QDEPTH      = 2;

    // wheel_size register and effective size both fit 9 bits
    localparam int CFG_W    = 9;
    localparam int SIZE_W   = CFG_W;
    localparam int SLOT_TOP = (SLOTS < 256) ? SLOTS : 256;
    localparam int SLOT_W   = $clog2(SLOT_TOP);
    localparam int IDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [1:0] {
        CMD_SUBMIT  = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ACCEPTED = 3'd0,
        STS_FULL     = 3'd1,
        STS_BAD      = 3'd2,
        STS_DONE     = 3'd3,
        STS_EXPIRED  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXPIRE
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  handle;
        logic [11:0] steps;
        logic        periodic;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_handle;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    // classified command as it sits in the queue
    typedef struct packed {
        t_cmd             cmd;
        logic [3:0]       handle;
        logic             handle_ok;   // handle names an existing entry index
        logic [IDX_W-1:0] idx;
        logic [11:0]      steps;
        logic             periodic;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    function automatic logic [SIZE_W-1:0] eff_size(logic [CFG_W-1:0] w);
        logic [SIZE_W-1:0] n;
        n = w;
        if (w == '0) n = SIZE_W'(1);
        if (32'(w) > SLOT_TOP) n = SIZE_W'(SLOT_TOP);
        return n;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_steps(logic [11:0] s, logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] r;
        r = n;
        if (s < 12'(n)) r = SIZE_W'(s);
        return r;
    endfunction

    // (base + add - sub) mod n, base < n, sub <= n; the sum can reach 2n
    function automatic logic [SLOT_W-1:0] wrap_slot(logic [SLOT_W-1:0] base, logic add,
                                                    logic [SIZE_W-1:0] sub,
                                                    logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] t;
        t = (SIZE_W+1)'(base) + (SIZE_W+1)'(add) + (SIZE_W+1)'(n) - (SIZE_W+1)'(sub);
        if (t >= (SIZE_W+1)'(n)) t = t - (SIZE_W+1)'(n);
        if (t >= (SIZE_W+1)'(n)) t = t - (SIZE_W+1)'(n);
        return SLOT_W'(t);
    endfunction

    function automatic logic [IDX_W-1:0] lowest_set(logic [TIMERS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (v[i]) r = IDX_W'(i);
        end
        return r;
    endfunction

endpackage

FILE: rtl/timing_wheel_scheduler.sv
// Timing wheel scheduler top level: front queue plus execution back end.
// Depends on tws_pkg, tws_front, tws_back.
//
//  channel   handshake                        payload
//  input     i_in_valid / o_in_ready          i_in_item  (t_in_item)
//  output    o_out_valid / i_out_ready        o_out_item (t_out_item)
//  config    i_cfg_we                         i_cfg_wdata (wheel_size)
//
// Submit, cancel and refresh each give one result. A tick with hits gives one result
// per expired entry (up to TIMERS), since the single result register emits one item
// per cycle while the output is not stalled; a tick with no hit gives one result.
// A two-entry queue lets the front keep accepting while the back end stalls.
// Synchronous active-low reset; no clearing pass, the table has per-entry valid bits.
module timing_wheel_scheduler import tws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_qhead head;
    logic   pop;

    tws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    tws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/tws_front.sv
// Timing wheel front end: takes input items, classifies them and queues them.
// Depends on tws_pkg.
module tws_front import tws_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output t_qhead   o_head,
    input  logic     i_pop
);

    t_op                r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    t_op                in_op;
    logic               push;
    logic               pop;

    always_comb begin
        in_op.cmd       = t_cmd'(i_item.cmd);
        in_op.handle    = i_item.handle;
        in_op.handle_ok = 32'(i_item.handle) < TIMERS;
        in_op.idx       = IDX_W'(i_item.handle);
        in_op.steps     = i_item.steps;
        in_op.periodic  = i_item.periodic;
    end

    assign o_ready      = r_count != QCNT_W'(QDEPTH);
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = r_count != '0;
    assign o_head.op    = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (32'(r_wptr) == QDEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (32'(r_rptr) == QDEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_op;
        end
    end

endmodule

FILE: rtl/tws_back.sv
// Timing wheel back end: timer table, cursor, command execution and result register.
// Depends on tws_pkg.
module tws_back import tws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_qhead           i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    t_state              r_state;
    t_state              n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [SLOT_W-1:0]   r_cursor;
    logic [SLOT_W-1:0]   n_cursor;
    logic [TIMERS-1:0]   r_valid;
    logic [TIMERS-1:0]   n_valid;
    logic [SLOT_W-1:0]   r_slot  [TIMERS];
    logic [11:0]         r_steps [TIMERS];
    logic                r_per   [TIMERS];
    logic [TIMERS-1:0]   r_mask;
    logic [TIMERS-1:0]   n_mask;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                out_free;
    logic                emit;
    t_out_item           out_item;
    logic [TIMERS-1:0]   hit;
    logic [IDX_W-1:0]    free_idx;
    logic                full;
    logic [IDX_W-1:0]    exp_idx;
    logic [TIMERS-1:0]   exp_rest;
    logic                exp_last;
    logic [SLOT_W-1:0]   cur_next;
    logic [IDX_W-1:0]    rd_idx;
    logic [11:0]         rd_steps;
    logic                rd_per;
    logic                wr_slot_en;
    logic                wr_new_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [SLOT_W-1:0]   wr_slot;
    logic                start;

    assign out_free = !r_out_valid || i_out_ready;
    assign start    = i_head.valid && out_free && (r_state == S_IDLE);

    // slot match for every entry against the current cursor
    always_comb begin
        for (int i = 0; i < TIMERS; i++) begin
            hit[i] = r_valid[i] && (r_slot[i] == r_cursor);
        end
    end

    assign full     = &r_valid;
    assign free_idx = lowest_set(~r_valid);
    assign exp_idx  = lowest_set(r_mask);
    assign exp_rest = r_mask & ~(TIMERS'(1) << exp_idx);
    assign exp_last = (exp_rest == '0) || (r_cnt == CNT_LAST);
    assign cur_next = (r_cursor == '0) ? SLOT_W'(r_size - 1'b1) : r_cursor - 1'b1;

    // one table read port, shared by refresh and expiry
    assign rd_idx   = (r_state == S_IDLE) ? i_head.op.idx : exp_idx;
    assign rd_steps = r_steps[rd_idx];
    assign rd_per   = r_per[rd_idx];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_head.op.cmd == CMD_TICK && hit != '0) begin
                    n_state = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (out_free && exp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        emit       = 1'b0;
        out_item   = '{result_handle: 4'd0, status: STS_DONE, last: 1'b1};
        n_cursor   = r_cursor;
        n_valid    = r_valid;
        n_mask     = r_mask;
        n_cnt      = r_cnt;
        wr_slot_en = 1'b0;
        wr_new_en  = 1'b0;
        wr_idx     = rd_idx;
        wr_slot    = r_cursor;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    case (i_head.op.cmd)
                        CMD_SUBMIT: begin
                            if (full) begin
                                out_item.status = STS_FULL;
                            end else begin
                                wr_idx     = free_idx;
                                wr_slot_en = 1'b1;
                                wr_new_en  = 1'b1;
                                n_valid[free_idx] = 1'b1;
                                if (i_head.op.steps > 12'(r_size)) begin
                                    wr_slot = wrap_slot(r_cursor, 1'b1, '0, r_size);
                                end else begin
                                    wr_slot = wrap_slot(r_cursor, 1'b0,
                                                        SIZE_W'(i_head.op.steps), r_size);
                                end
                                out_item.result_handle = 4'(free_idx);
                                out_item.status        = STS_ACCEPTED;
                            end
                        end
                        CMD_CANCEL, CMD_REFRESH: begin
                            out_item.result_handle = i_head.op.handle;
                            if (!i_head.op.handle_ok || !r_valid[i_head.op.idx]) begin
                                out_item.status = STS_BAD;
                            end else begin
                                out_item.status = STS_ACCEPTED;
                                if (i_head.op.cmd == CMD_CANCEL) begin
                                    n_valid[i_head.op.idx] = 1'b0;
                                end else begin
                                    wr_slot_en = 1'b1;
                                    wr_slot    = wrap_slot(r_cursor, 1'b0,
                                                           clamp_steps(rd_steps, r_size),
                                                           r_size);
                                end
                            end
                        end
                        default: begin
                            // tick: snapshot the slot, move the cursor
                            n_cursor = cur_next;
                            n_cnt    = '0;
                            if (hit != '0) begin
                                emit   = 1'b0;
                                n_mask = hit;
                            end
                        end
                    endcase
                end
            end
            S_EXPIRE: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    out_item.result_handle = 4'(exp_idx);
                    out_item.status        = STS_EXPIRED;
                    out_item.last          = exp_last;
                    n_mask                 = exp_last ? '0 : exp_rest;
                    n_cnt                  = r_cnt + 1'b1;
                    if (rd_per) begin
                        wr_slot_en = 1'b1;
                        wr_slot    = wrap_slot(r_cursor, 1'b1,
                                               clamp_steps(rd_steps, r_size), r_size);
                    end else begin
                        n_valid[exp_idx] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= eff_size(CFG_W'(256));
            r_cursor    <= SLOT_W'(SLOT_TOP - 1);
            r_valid     <= '0;
            r_mask      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            // new wheel: drop every entry, restart the cursor
            r_state     <= S_IDLE;
            r_size      <= eff_size(i_cfg_wdata);
            r_cursor    <= SLOT_W'(eff_size(i_cfg_wdata) - 1'b1);
            r_valid     <= '0;
            r_mask      <= '0;
            r_cnt       <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out_item <= out_item;
        end
        if (wr_slot_en) begin
            r_slot[wr_idx] <= wr_slot;
        end
        if (wr_new_en) begin
            r_steps[wr_idx] <= i_head.op.steps;
            r_per[wr_idx]   <= i_head.op.periodic;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_expire_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXPIRE |-> r_mask != '0)
        else $error("expiry pass with empty mask");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_cursor) < r_size))
        else $error("cursor outside wheel");

    a_expire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPIRE && out_free) |-> r_valid[exp_idx])
        else $error("expiring a free entry");

    a_tick_enters_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !i_cfg_we && i_head.op.cmd == CMD_TICK && hit != '0)
            |=> r_state == S_EXPIRE)
        else $error("tick with hits did not start expiry");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && i_head.valid))
        else $error("queue popped outside idle");

endmodule

FILE: bench/timing_wheel_scheduler_test.sv
// Self-checking bench for timing_wheel_scheduler: timer commands are predicted against an
// in-bench timing wheel and every result item is compared as it leaves the block.
// Depends on tws_pkg and the RTL of timing_wheel_scheduler.
module timing_wheel_scheduler_test;
    import tws_pkg::*;

    localparam int PERIOD         = 20;
    localparam int HOLD_LEN       = 300;
    localparam int SETTLE         = 40;
    localparam int TAIL           = 60;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int PRINT_CAP      = 50;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 18;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_item   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_ready;
    logic             out_valid;
    t_out_item        out_item;

    timing_wheel_scheduler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // wheel settings per random phase; the last one is drawn at run time
    int unsigned phase_size [PHASES] = '{256, 1, 0, 511, 2, 7, 300, 37, 256, 0};

    // in-bench copy of the wheel
    int unsigned wheel_cfg;
    int unsigned cursor_pos;
    bit          timer_live  [TIMERS];
    int unsigned timer_slot  [TIMERS];
    logic [11:0] timer_steps [TIMERS];
    bit          timer_rearm [TIMERS];

    t_in_item  cmd_pending[$];
    t_out_item result_due[$];

    int  err_count   = 0;
    int  n_cmds      = 0;
    int  n_results   = 0;
    int  n_expired   = 0;
    int  n_settings  = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;
    int  hold_seq    = 0;
    int  hold_seen   = 0;
    int  hold_left   = 0;

    initial begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * PERIOD);
        $display("timeout: %0d results still due", result_due.size());
        $display("FAIL timing_wheel_scheduler");
        $finish;
    end

    function automatic int unsigned size_now();
        int unsigned n;
        n = wheel_cfg;
        if (n == 0) n = 1;
        if (n > SLOT_TOP) n = SLOT_TOP;
        return n;
    endfunction

    function automatic void wheel_clear();
        for (int i = 0; i < TIMERS; i++) timer_live[i] = 1'b0;
        cursor_pos = size_now() - 1;
    endfunction

    function automatic int unsigned slot_at(int unsigned base, int unsigned add,
                                            int unsigned sub, int unsigned n);
        return (base + add + n - sub) % n;
    endfunction

    function automatic t_in_item cmd_item(t_cmd c, int unsigned h, int unsigned st,
                                          int unsigned per);
        t_in_item it;
        it.cmd      = c;
        it.handle   = 4'(h);
        it.steps    = 12'(st);
        it.periodic = per[0];
        return it;
    endfunction

    // applies one command to the wheel copy and queues the result items it causes
    function automatic void wheel_results(t_in_item it);
        int unsigned n, s, old, free_idx;
        bit          hit [TIMERS];
        t_out_item   r;
        t_out_item   burst[$];
        n = size_now();
        if (cursor_pos >= n) cursor_pos = n - 1;
        r.last = 1'b1;
        case (t_cmd'(it.cmd))
            CMD_SUBMIT: begin
                free_idx = TIMERS;
                for (int i = TIMERS - 1; i >= 0; i--) if (!timer_live[i]) free_idx = i;
                if (free_idx == TIMERS) begin
                    r.result_handle = '0;
                    r.status        = STS_FULL;
                end else begin
                    timer_live[free_idx]  = 1'b1;
                    timer_steps[free_idx] = it.steps;
                    timer_rearm[free_idx] = it.periodic;
                    timer_slot[free_idx]  = (it.steps > n) ? slot_at(cursor_pos, 1, 0, n)
                                                           : slot_at(cursor_pos, 0, it.steps, n);
                    r.result_handle = 4'(free_idx);
                    r.status        = STS_ACCEPTED;
                end
                burst.push_back(r);
            end
            CMD_CANCEL, CMD_REFRESH: begin
                r.result_handle = it.handle;
                if (int'(it.handle) >= TIMERS || !timer_live[it.handle]) begin
                    r.status = STS_BAD;
                end else begin
                    r.status = STS_ACCEPTED;
                    if (t_cmd'(it.cmd) == CMD_CANCEL) begin
                        timer_live[it.handle] = 1'b0;
                    end else begin
                        s = (timer_steps[it.handle] > n) ? n : timer_steps[it.handle];
                        timer_slot[it.handle] = slot_at(cursor_pos, 0, s, n);
                    end
                end
                burst.push_back(r);
            end
            default: begin
                // snapshot the cursor slot before anything is re-filed
                old = cursor_pos;
                for (int i = 0; i < TIMERS; i++) hit[i] = timer_live[i] && timer_slot[i] == old;
                cursor_pos = (old == 0) ? n - 1 : old - 1;
                for (int i = 0; i < TIMERS; i++) begin
                    if (hit[i] && burst.size() < MAX_RESULTS) begin
                        if (timer_rearm[i]) begin
                            s = (timer_steps[i] > n) ? n : timer_steps[i];
                            timer_slot[i] = slot_at(cursor_pos, 1, s, n);
                        end else begin
                            timer_live[i] = 1'b0;
                        end
                        r.result_handle = 4'(i);
                        r.status        = STS_EXPIRED;
                        r.last          = 1'b0;
                        burst.push_back(r);
                    end
                end
                if (burst.size() == 0) begin
                    r.result_handle = '0;
                    r.status        = STS_DONE;
                    r.last          = 1'b1;
                    burst.push_back(r);
                end else begin
                    burst[$].last = 1'b1;
                end
            end
        endcase
        foreach (burst[k]) result_due.push_back(burst[k]);
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic wait_drain();
        do @(posedge clk);
        while (cmd_pending.size() != 0 || in_valid || result_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_wheel(int unsigned v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        wheel_cfg = v & 32'h1FF;
        wheel_clear();
        n_settings++;
    endtask

    // sender: predicts on acceptance, then offers the next pending item
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                wheel_results(in_item);
                n_cmds++;
            end
            if (!in_valid || in_ready) begin
                if (cmd_pending.size() != 0 && !(tx_idle_en && $urandom_range(99) < 10)) begin
                    in_item  <= cmd_pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result item, stalls at random or for a long hold-off
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (out_item.status == STS_EXPIRED) n_expired++;
                if (result_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result handle %0d status %0d",
                                              out_item.result_handle, out_item.status));
                end else begin
                    want = result_due.pop_front();
                    if (out_item.result_handle != want.result_handle)
                        report_mismatch($sformatf("result_handle %0d, want %0d",
                                                  out_item.result_handle, want.result_handle));
                    if (out_item.status != want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_item.status, want.status));
                    if (out_item.last != want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  out_item.last, want.last));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_LEN;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(rx_idle_en && $urandom_range(99) < 10);
            end
        end
    end

    initial begin
        int unsigned sz, n, lim, st, r, r2, h;
        t_cmd        c;
        wheel_cfg = 256;
        wheel_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small wheel so several timers share a slot, cursor starts at 3
        write_wheel(4);
        cmd_pending.push_back(cmd_item(CMD_TICK, 9, 4095, 1));       // empty wheel
        cmd_pending.push_back(cmd_item(CMD_SUBMIT, 15, 0, 0));       // due on next tick
        cmd_pending.push_back(cmd_item(CMD_SUBMIT, 0, 1, 1));
        cmd_pending.push_back(cmd_item(CMD_SUBMIT, 0, 4, 0));        // steps equal to size
        cmd_pending.push_back(cmd_item(CMD_SUBMIT, 0, 5, 1));        // just over range
        cmd_pending.push_back(cmd_item(CMD_SUBMIT, 0, 4095, 1));     // far over range
        cmd_pending.push_back(cmd_item(CMD_CANCEL, 5, 0, 0));        // free entry
        cmd_pending.push_back(cmd_item(CMD_REFRESH, 4, 0, 0));       // clamps stored steps
        cmd_pending.push_back(cmd_item(CMD_TICK, 0, 0, 0));
        for (int i = 0; i < 14; i++)                                 // last one finds it full
            cmd_pending.push_back(cmd_item(CMD_SUBMIT, 15 - i, i % 6, i % 2));
        cmd_pending.push_back(cmd_item(CMD_TICK, 15, 0, 1));
        cmd_pending.push_back(cmd_item(CMD_TICK, 0, 4095, 0));
        cmd_pending.push_back(cmd_item(CMD_CANCEL, 15, 0, 0));
        cmd_pending.push_back(cmd_item(CMD_CANCEL, 15, 0, 0));       // now free
        cmd_pending.push_back(cmd_item(CMD_REFRESH, 1, 4095, 1));
        wait_drain();

        // random phases over several wheel settings
        for (int p = 0; p < PHASES; p++) begin
            sz = (p == PHASES - 1) ? $urandom_range(256, 1) : phase_size[p];
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2);
            write_wheel(sz);
            n   = size_now();
            lim = (n + 1 < 20) ? n + 1 : 20;
            if (p == 5) hold_seq++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r  = $urandom_range(99);
                r2 = $urandom_range(99);
                st = (r2 < 60) ? $urandom_range(lim) :
                     (r2 < 85) ? $urandom_range(n + 1) : $urandom_range(4095);
                h  = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(15);
                if (r < 30)      c = CMD_SUBMIT;
                else if (r < 42) c = CMD_CANCEL;
                else if (r < 55) c = CMD_REFRESH;
                else             c = CMD_TICK;
                cmd_pending.push_back(cmd_item(c, h, st, $urandom_range(1)));
            end
            wait_drain();
        end

        repeat (TAIL) @(posedge clk);
        if (result_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", result_due.size()));
        $display("ran %0d commands over %0d wheel settings, including a %0d-cycle output stall",
                 n_cmds, n_settings, HOLD_LEN);
        $display("checked %0d result items, %0d of them expirations, %0d mismatches",
                 n_results, n_expired, err_count);
        if (err_count == 0) begin
            $display("PASS timing_wheel_scheduler");
        end else begin
            $display("FAIL timing_wheel_scheduler");
        end
        $finish;
    end

endmodule
